FILE: design/char_to_entity_encoder_assert.svh
// ----------------------------------------------------------------------------
// char_to_entity_encoder_assert.svh
// Assertion macros shared by the entity encoder modules.
// ----------------------------------------------------------------------------
`ifndef CHAR_TO_ENTITY_ENCODER_ASSERT_SVH
`define CHAR_TO_ENTITY_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define CET_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CET_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CET_ASSERT(label, clk, rst_n, prop, msg)
`define CET_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Types, constants and helpers of the character-to-entity encoder.
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int TABLE_DEPTH_DEF    = 256;
    localparam int MAX_NAME_CHARS_DEF = 8;

    localparam int COUNT_W    = 9;
    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = 8 * TEXT_BYTES;
    localparam int LEN_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_ENCODE = 1'b1;
    // register index, taken from paddr[2]
    localparam logic        REG_ENTRY_COUNT = 1'b0;

    localparam logic [15:0] NO_CHAR_CODE = 16'hFFFF;
    localparam logic [15:0] SHORT_HEX_MAX = 16'd255;

    localparam logic [7:0]  CHAR_AMP  = 8'h26;
    localparam logic [7:0]  CHAR_HASH = 8'h23;
    localparam logic [7:0]  CHAR_X    = 8'h78;
    localparam logic [7:0]  CHAR_SEMI = 8'h3B;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_A_OFS = 8'h37;   // 'A' - 10

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } t_srch_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_AMP,
        E_BODY,
        E_SEMI
    } t_emit_state;

    // Text run handed from the search to the emitter. Body bytes low first.
    typedef struct packed {
        logic              valid;
        logic              named;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
    } t_emit_req;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + {4'b0, nib};
        end else begin
            return CHAR_A_OFS + {4'b0, nib};
        end
    endfunction

    // "#x" plus two or four uppercase digits
    function automatic t_emit_req hex_req(input logic [15:0] code);
        t_emit_req req;
        req       = '0;
        req.valid = 1'b1;
        req.named = 1'b0;
        req.text[7:0]  = CHAR_HASH;
        req.text[15:8] = CHAR_X;
        if (code > SHORT_HEX_MAX) begin
            req.text[23:16] = hex_char(code[15:12]);
            req.text[31:24] = hex_char(code[11:8]);
            req.text[39:32] = hex_char(code[7:4]);
            req.text[47:40] = hex_char(code[3:0]);
            req.len         = LEN_W'(6);
        end else begin
            req.text[23:16] = hex_char(code[7:4]);
            req.text[31:24] = hex_char(code[3:0]);
            req.len         = LEN_W'(4);
        end
        return req;
    endfunction

endpackage

FILE: design/cet_table.sv
// ----------------------------------------------------------------------------
// cet_table
// Code and name storage, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cet_table #(
    parameter int TABLE_DEPTH    = cet_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_NAME_CHARS = cet_pkg::MAX_NAME_CHARS_DEF,
    parameter int AW             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int NW             = 8 * MAX_NAME_CHARS
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_code,
    input  logic [NW-1:0] i_wr_name,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_code,
    output logic [NW-1:0] o_rd_name
);

    logic [15:0]   r_code_mem [TABLE_DEPTH];
    logic [NW-1:0] r_name_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_code_mem[i_wr_addr] <= i_wr_code;
            r_name_mem[i_wr_addr] <= i_wr_name;
        end
        o_rd_code <= r_code_mem[i_rd_addr];
        o_rd_name <= r_name_mem[i_rd_addr];
    end

endmodule

FILE: design/cet_search.sv
// ----------------------------------------------------------------------------
// cet_search
// Item intake and binary search sequencer over the code table.
// ----------------------------------------------------------------------------
`include "char_to_entity_encoder_assert.svh"

module cet_search #(
    parameter int TABLE_DEPTH    = cet_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_NAME_CHARS = cet_pkg::MAX_NAME_CHARS_DEF,
    parameter int AW             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int NW             = 8 * MAX_NAME_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic [15:0]                   i_char_code,
    input  logic [cet_pkg::COUNT_W-1:0]   i_count,
    input  logic                          i_emit_busy,
    output logic                          o_ready,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [15:0]                   i_rd_code,
    input  logic [NW-1:0]                 i_rd_name,
    output cet_pkg::t_emit_req            o_req
);
    import cet_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_srch_state   r_state, n_state;
    logic [CW-1:0] r_base, n_base;
    logic [CW-1:0] r_len, n_len;
    logic [15:0]   r_key, n_key;
    logic [AW-1:0] r_probe, n_probe;

    logic [CW-1:0] w_count;
    logic [CW-1:0] w_probe;
    logic [CW-1:0] w_len_next;

    assign w_count = (32'(i_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(i_count);
    assign w_probe = r_base + (r_len >> 1);
    assign o_rd_addr = AW'(w_probe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_base  <= n_base;
        r_len   <= n_len;
        r_key   <= n_key;
        r_probe <= n_probe;
    end

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_len      = r_len;
        n_key      = r_key;
        n_probe    = r_probe;
        o_req      = '0;
        o_ready    = (r_state == S_IDLE) && !i_emit_busy;
        w_len_next = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready && (i_opcode == OP_ENCODE)) begin
                    n_key = i_char_code;
                    if ((i_char_code == NO_CHAR_CODE) || (w_count == '0)) begin
                        o_req = hex_req(i_char_code);
                    end else begin
                        n_base  = '0;
                        n_len   = w_count;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // table read issued at w_probe, data lands next cycle
                n_probe = AW'(w_probe);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_key == i_rd_code) begin
                    o_req.valid = 1'b1;
                    o_req.named = 1'b1;
                    o_req.text  = TEXT_W'(i_rd_name);
                    o_req.len   = LEN_W'(MAX_NAME_CHARS);
                    n_state     = S_IDLE;
                end else begin
                    if (r_key > i_rd_code) begin
                        n_base     = CW'(r_probe) + CW'(1);
                        w_len_next = (r_len - CW'(1)) >> 1;
                    end else begin
                        w_len_next = r_len >> 1;
                    end
                    n_len = w_len_next;
                    if (w_len_next == '0) begin
                        o_req   = hex_req(r_key);
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CET_ASSERT(a_cmp_after_probe, i_clk, i_rst_n, (r_state == S_CMP) |-> ($past(r_state) == S_PROBE), "compare without a preceding probe")
    `CET_ASSERT(a_probe_window, i_clk, i_rst_n, (r_state == S_PROBE) |-> (r_len != '0), "probe with an empty window")
    `CET_ASSERT(a_probe_in_range, i_clk, i_rst_n, (r_state == S_PROBE) |-> (32'(w_probe) < 32'(TABLE_DEPTH)), "probe beyond the table")
    `CET_ASSERT(a_req_when_free, i_clk, i_rst_n, o_req.valid |-> !i_emit_busy, "text run issued while emitter busy")

endmodule

FILE: design/cet_emit.sv
// ----------------------------------------------------------------------------
// cet_emit
// Byte sequencer and output register for one entity text run.
// ----------------------------------------------------------------------------
`include "char_to_entity_encoder_assert.svh"

module cet_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cet_pkg::t_emit_req i_req,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte,
    output logic               o_named_hit
);
    import cet_pkg::*;

    t_emit_state       r_state, n_state;
    logic [TEXT_W-1:0] r_text, n_text;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_named, n_named;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_named, n_out_named;

    logic              w_free;
    logic              w_load;
    logic [7:0]        w_byte;
    logic              w_last;

    assign w_free      = !r_out_valid || i_ready;
    assign o_busy      = (r_state != E_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_named_hit = r_out_named;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_text      <= n_text;
        r_left      <= n_left;
        r_named     <= n_named;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_named <= n_out_named;
    end

    always_comb begin
        n_state = r_state;
        n_text  = r_text;
        n_left  = r_left;
        n_named = r_named;
        w_load  = 1'b0;
        w_byte  = '0;
        w_last  = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (i_req.valid) begin
                    n_text  = i_req.text;
                    n_left  = i_req.len;
                    n_named = i_req.named;
                    n_state = E_AMP;
                end
            end
            E_AMP: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    w_byte  = CHAR_AMP;
                    n_state = E_BODY;
                end
            end
            E_BODY: begin
                // a name ends at its first zero byte or at full length
                if ((r_left == '0) || (r_text[7:0] == 8'h00)) begin
                    n_state = E_SEMI;
                end else if (w_free) begin
                    w_load = 1'b1;
                    w_byte = r_text[7:0];
                    n_text = r_text >> 8;
                    n_left = r_left - LEN_W'(1);
                end
            end
            E_SEMI: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    w_byte  = CHAR_SEMI;
                    w_last  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase

        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_named = r_out_named;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_byte;
            n_out_last  = w_last;
            n_out_named = r_named;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    `CET_ASSERT(a_start_idle, i_clk, i_rst_n, i_req.valid |-> (r_state == E_IDLE), "text run started while busy")
    `CET_ASSERT(a_body_done, i_clk, i_rst_n, ((r_state == E_BODY) && (r_left == '0)) |=> (r_state == E_SEMI), "body overran its length")
    `CET_ASSERT(a_last_on_semi, i_clk, i_rst_n, (w_load && (r_state == E_SEMI)) |=> (o_valid && o_last_byte && (o_out_byte == CHAR_SEMI)), "closing byte not flagged last")
    `CET_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

FILE: design/char_to_entity_encoder.sv
// ----------------------------------------------------------------------------
// char_to_entity_encoder
// XML entity encoder: loadable code/name table, binary search, byte output.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_opcode i_entry_index i_entry_code
//                                          i_entry_name i_char_code
// output    out        o_valid / i_ready  o_out_byte o_last_byte o_named_hit
// config    in         APB (pready = 1)   entry_count at byte address 0
//
// A load transaction writes the table when taken. An encode transaction runs a
// table read and a compare for each probe (at most log2(TABLE_DEPTH)+1
// probes), then emits the text bytes and finds the end of the body. The
// single table read port sets the probe rate. Reset is synchronous and clears
// control state and entry_count; table contents are undefined until loaded. A
// stalled output holds the sequencer and no new transaction is taken until the
// run is out.
// ----------------------------------------------------------------------------
module char_to_entity_encoder #(
    parameter int TABLE_DEPTH    = cet_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_NAME_CHARS = cet_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [7:0]                        i_entry_index,
    input  logic [15:0]                       i_entry_code,
    input  logic [63:0]                       i_entry_name,
    input  logic [15:0]                       i_char_code,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_byte,
    output logic                              o_named_hit,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cet_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cet_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cet_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import cet_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = 8 * MAX_NAME_CHARS;

    logic [COUNT_W-1:0] r_entry_count;
    logic               w_cfg_wr;
    logic               w_load;
    logic [AW-1:0]      w_rd_addr;
    logic [15:0]        w_rd_code;
    logic [NW-1:0]      w_rd_name;
    logic               w_emit_busy;
    t_emit_req          w_req;

    // config register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata   = (paddr[2] == REG_ENTRY_COUNT) ? APB_DATA_W'(r_entry_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (w_cfg_wr) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    // slots beyond the table are dropped
    assign w_load = i_valid && o_ready && (i_opcode == OP_LOAD)
                    && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    cet_table #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_code (i_entry_code),
        .i_wr_name (i_entry_name[NW-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_code (w_rd_code),
        .o_rd_name (w_rd_name)
    );

    cet_search #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_count     (r_entry_count),
        .i_emit_busy (w_emit_busy),
        .o_ready     (o_ready),
        .o_rd_addr   (w_rd_addr),
        .i_rd_code   (w_rd_code),
        .i_rd_name   (w_rd_name),
        .o_req       (w_req)
    );

    cet_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_busy      (w_emit_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_named_hit (o_named_hit)
    );

endmodule
